// ===== sv/banked_register_file_mode_switch_unit_assert.svh =====
// -----------------------------------------------------------------------------
// Banked register file assertion macros
// Shared property forms for the register file's internal checks.
// -----------------------------------------------------------------------------
`ifndef BANKED_REGISTER_FILE_MODE_SWITCH_UNIT_ASSERT_SVH
`define BANKED_REGISTER_FILE_MODE_SWITCH_UNIT_ASSERT_SVH

// Same-cycle implication, quiet during reset.
`define BRF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, quiet during reset.
`define BRF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/brf_ms_pkg.sv =====
// -----------------------------------------------------------------------------
// Banked register file package
// Op and bank codes, storage layout and the bank switch move schedule.
// -----------------------------------------------------------------------------
`default_nettype none

package brf_ms_pkg;

  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_MODE  = 2'd2;

  localparam logic [2:0] BANK_USR = 3'd0;
  localparam logic [2:0] BANK_FIQ = 3'd1;
  localparam logic [2:0] BANK_IRQ = 3'd2;
  localparam logic [2:0] BANK_SVC = 3'd3;
  localparam logic [2:0] BANK_ABT = 3'd4;
  localparam logic [2:0] BANK_UND = 3'd5;
  localparam logic [2:0] BANK_DUM = 3'd6;

  localparam logic [4:0] MODE_RESET = 5'd16;

  // Storage: words 0..15 visible registers, 16..37 banked copies.
  localparam int unsigned NUM_WORDS = 38;
  localparam int unsigned ADDR_W    = $clog2(NUM_WORDS);
  localparam logic [ADDR_W-1:0] COPY_BASE = ADDR_W'(16);
  localparam logic [ADDR_W-1:0] FIQ_COPY  = ADDR_W'(7);

  // r13 sits this many places above r8.
  localparam logic [2:0] SP_OFS = 3'd5;

  // Seven save slots (r8..r14), seven restore slots, one flush slot.
  localparam logic [3:0] SLOT_RESTORE = 4'd7;
  localparam logic [3:0] SLOT_FLUSH   = 4'd14;

  typedef struct packed {
    logic              en;
    logic              zero;
    logic [ADDR_W-1:0] src;
    logic [ADDR_W-1:0] dst;
  } brf_move_t;

  function automatic logic [2:0] bank_of(input logic [4:0] mode);
    logic [2:0] b;
    case (mode) inside
      5'd0, 5'd16, 5'd31: b = BANK_USR;
      5'd1, 5'd17:        b = BANK_FIQ;
      5'd2, 5'd18:        b = BANK_IRQ;
      5'd3, 5'd19:        b = BANK_SVC;
      5'd23:              b = BANK_ABT;
      5'd27:              b = BANK_UND;
      default:            b = BANK_DUM;
    endcase
    return b;
  endfunction

  // Copy slot of r13 for the banks that only bank r13..r14.
  function automatic logic [ADDR_W-1:0] sp_copy(input logic [2:0] bank);
    logic [ADDR_W-1:0] s;
    case (bank)
      BANK_USR: s = ADDR_W'(5);
      BANK_IRQ: s = ADDR_W'(14);
      BANK_SVC: s = ADDR_W'(16);
      BANK_ABT: s = ADDR_W'(18);
      BANK_UND: s = ADDR_W'(20);
      default:  s = '0;
    endcase
    return s;
  endfunction

  function automatic brf_move_t move_for(input logic [2:0] from_b,
                                         input logic [2:0] to_b,
                                         input logic [3:0] slot);
    brf_move_t         m;
    logic [2:0]        j;
    logic [ADDR_W-1:0] jw;
    logic [ADDR_W-1:0] rw;
    m  = '0;
    j  = '0;
    if (slot < SLOT_RESTORE) begin
      j = slot[2:0];
    end else if (slot < SLOT_FLUSH) begin
      j = 3'(slot - SLOT_RESTORE);
    end
    jw = ADDR_W'(j);
    rw = ADDR_W'({1'b1, j});
    if (slot < SLOT_RESTORE) begin
      // save outgoing bank
      m.src = rw;
      if (from_b == BANK_FIQ) begin
        m.en  = 1'b1;
        m.dst = COPY_BASE + FIQ_COPY + jw;
      end else if (from_b != BANK_DUM) begin
        if (j < SP_OFS) begin
          m.en  = (to_b == BANK_FIQ);
          m.dst = COPY_BASE + jw;
        end else begin
          m.en  = 1'b1;
          m.dst = COPY_BASE + sp_copy(from_b) + (jw - ADDR_W'(SP_OFS));
        end
      end
    end else if (slot < SLOT_FLUSH) begin
      // restore incoming bank
      m.dst = rw;
      if (to_b == BANK_FIQ) begin
        m.en  = 1'b1;
        m.src = COPY_BASE + FIQ_COPY + jw;
      end else if (to_b == BANK_DUM) begin
        m.en   = 1'b1;
        m.zero = 1'b1;
      end else if (j < SP_OFS) begin
        m.en  = (from_b == BANK_FIQ);
        m.src = COPY_BASE + jw;
      end else begin
        m.en  = 1'b1;
        m.src = COPY_BASE + sp_copy(to_b) + (jw - ADDR_W'(SP_OFS));
      end
    end
    return m;
  endfunction

endpackage

`default_nettype wire

// ===== sv/banked_register_file_mode_switch_unit.sv =====
// -----------------------------------------------------------------------------
// Banked register file with mode switch
// Sixteen visible words plus mode-banked copies in one synchronous memory.
// -----------------------------------------------------------------------------
// One item at a time. A write, an unused op or a mode change within the same
// bank passes through the hold state to the result register; a read first
// waits in a read-wait state for the registered memory read. A bank change
// walks a fixed 14-slot save/restore schedule through the single read and
// write port of the storage memory, one slot a cycle, and one flush slot.
// A new item is taken as soon as the previous one sits in the result register.
// Reset needs no clearing pass: 38 valid bits make unwritten words read as 0.
`default_nettype none

`include "banked_register_file_mode_switch_unit_assert.svh"

module banked_register_file_mode_switch_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  op_i,
  input  wire logic [3:0]  reg_index_i,
  input  wire logic [31:0] write_value_i,
  input  wire logic [4:0]  new_mode_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [31:0]      read_value_o,
  output logic [2:0]       active_bank_o,
  output logic [4:0]       active_mode_o
);
  import brf_ms_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_RDWAIT = 2'd1;
  localparam logic [1:0] ST_MOVE   = 2'd2;
  localparam logic [1:0] ST_HOLD   = 2'd3;

  logic [1:0]        state_q, state_d;
  logic [3:0]        slot_q;
  logic [4:0]        mode_q;
  logic [2:0]        from_q, to_q;
  logic              wpend_en_q;
  logic              wpend_zero_q;
  logic [ADDR_W-1:0] wpend_dst_q;
  logic [NUM_WORDS-1:0] valid_q;
  logic              rd_valid_q;
  logic [31:0]       rdata_q;
  logic [31:0]       pend_val_q;
  logic              out_valid_q;
  logic [31:0]       read_value_q;
  logic [2:0]        active_bank_q;
  logic [4:0]        active_mode_q;

  logic [31:0]       mem [NUM_WORDS];

  logic              in_xfer;
  logic              out_load;
  logic [2:0]        cur_bank, tgt_bank;
  brf_move_t         mv;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [31:0]       rd_data;
  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [31:0]       wdata;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign cur_bank   = bank_of(mode_q);
  assign tgt_bank   = bank_of(new_mode_i);
  assign mv         = move_for(from_q, to_q, slot_q);
  assign out_load   = (state_q == ST_HOLD) && (!out_valid_q || !out_stall_i);

  // never-written words read as zero
  assign rd_data = rd_valid_q ? rdata_q : '0;

  always_comb begin
    if (state_q == ST_MOVE) begin
      rd_addr = mv.src;
      rd_en   = mv.en && !mv.zero;
    end else begin
      rd_addr = ADDR_W'(reg_index_i);
      rd_en   = in_xfer && (op_i == OP_READ);
    end
  end

  // Moves are pipelined: read in one slot, write back in the next.
  always_comb begin
    if (wpend_en_q) begin
      we    = 1'b1;
      waddr = wpend_dst_q;
      wdata = wpend_zero_q ? '0 : rd_data;
    end else begin
      we    = in_xfer && (op_i == OP_WRITE);
      waddr = ADDR_W'(reg_index_i);
      wdata = write_value_i;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          if (op_i == OP_READ) begin
            state_d = ST_RDWAIT;
          end else if (op_i == OP_MODE && cur_bank != tgt_bank) begin
            state_d = ST_MOVE;
          end else begin
            state_d = ST_HOLD;
          end
        end
      end
      ST_RDWAIT: state_d = ST_HOLD;
      ST_MOVE: begin
        if (slot_q == SLOT_FLUSH) begin
          state_d = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      slot_q      <= '0;
      mode_q      <= MODE_RESET;
      from_q      <= BANK_USR;
      to_q        <= BANK_USR;
      wpend_en_q  <= 1'b0;
      valid_q     <= '0;
      rd_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      wpend_en_q <= (state_q == ST_MOVE) && mv.en;
      if (in_xfer && op_i == OP_MODE) begin
        mode_q <= new_mode_i;
        from_q <= cur_bank;
        to_q   <= tgt_bank;
        slot_q <= '0;
      end else if (state_q == ST_MOVE) begin
        slot_q <= slot_q + 4'd1;
      end
      if (we) begin
        valid_q[waddr] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid_q <= valid_q[rd_addr];
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_MOVE) begin
      wpend_dst_q  <= mv.dst;
      wpend_zero_q <= mv.zero;
    end
    if (in_xfer) begin
      pend_val_q <= '0;
    end else if (state_q == ST_RDWAIT) begin
      pend_val_q <= rd_data;
    end
    if (out_load) begin
      read_value_q  <= pend_val_q;
      active_bank_q <= cur_bank;
      active_mode_q <= mode_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign read_value_o  = read_value_q;
  assign active_bank_o = active_bank_q;
  assign active_mode_o = active_mode_q;

  `BRF_ASSERT_NOW(a_no_write_in_rdwait, state_q == ST_RDWAIT, !we,
    "memory written while a read is in flight")
  `BRF_ASSERT_NEXT(a_same_bank_skips_moves,
    in_xfer && op_i == OP_MODE && cur_bank == tgt_bank, state_q == ST_HOLD,
    "same-bank mode change started a move sequence")
  `BRF_ASSERT_NEXT(a_move_flush_ends, state_q == ST_MOVE && slot_q == SLOT_FLUSH,
    state_q == ST_HOLD && !wpend_en_q, "move sequence did not end after flush")
  `BRF_ASSERT_NOW(a_result_from_hold, $rose(out_valid_o), $past(state_q == ST_HOLD),
    "result register loaded outside the hold state")

endmodule

`default_nettype wire

// ===== sim/banked_register_file_mode_switch_unit_tb.sv =====
// -----------------------------------------------------------------------------
// Banked register file mode switch testbench
// Drives reads, writes, mode changes and unused ops through the valid/stall
// input port, predicts each result from a local model of the visible and
// banked registers, and checks every output transfer in order.
// -----------------------------------------------------------------------------
`timescale 1ns / 100ps

module banked_register_file_mode_switch_unit_tb;
  import brf_ms_pkg::*;

  localparam logic [1:0] OP_NONE = 2'd3;  // unused code, leaves state alone
  localparam int STUCK_LIMIT   = 2000;
  localparam int DRAIN_CYCLES  = 40;
  localparam int RANDOM_ITEMS  = 550;

  typedef struct packed {
    logic [1:0]  op;
    logic [3:0]  idx;
    logic [31:0] wval;
    logic [4:0]  nmode;
  } rf_access_t;

  typedef struct packed {
    logic [31:0] rval;
    logic [2:0]  bank;
    logic [4:0]  mode;
  } rf_result_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        in_valid_i    = 1'b0;
  logic        in_stall_o;
  logic [1:0]  op_i          = OP_READ;
  logic [3:0]  reg_index_i   = '0;
  logic [31:0] write_value_i = '0;
  logic [4:0]  new_mode_i    = '0;
  logic        out_valid_o;
  logic        out_stall_i   = 1'b0;
  logic [31:0] read_value_o;
  logic [2:0]  active_bank_o;
  logic [4:0]  active_mode_o;

  banked_register_file_mode_switch_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .op_i          (op_i),
    .reg_index_i   (reg_index_i),
    .write_value_i (write_value_i),
    .new_mode_i    (new_mode_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .read_value_o  (read_value_o),
    .active_bank_o (active_bank_o),
    .active_mode_o (active_mode_o)
  );

  always #5 clk_i = ~clk_i;

  rf_access_t access_q[$];
  rf_result_t result_q[$];
  rf_access_t next_access;
  rf_result_t want;

  // model state
  logic [31:0] gpr[16];
  logic [31:0] shadow[22];
  logic [4:0]  cur_mode;

  int  mismatches = 0;
  int  n_taken = 0;
  int  n_checked = 0;
  int  n_reads = 0;
  int  n_writes = 0;
  int  n_modes = 0;
  int  bank_swaps = 0;
  int  stuck = 0;
  logic in_xfer = 1'b0;
  logic quiet;

  // no idling on either side for a stretch in the middle of the run
  assign quiet = (n_taken >= 200) && (n_taken < 330);

  function automatic logic [2:0] mode_bank(input logic [4:0] m);
    case (m)
      5'd0, 5'd16, 5'd31: return BANK_USR;
      5'd1, 5'd17:        return BANK_FIQ;
      5'd2, 5'd18:        return BANK_IRQ;
      5'd3, 5'd19:        return BANK_SVC;
      5'd23:              return BANK_ABT;
      5'd27:              return BANK_UND;
      default:            return BANK_DUM;
    endcase
  endfunction

  // shadow index of r13 for banks holding only r13/r14
  function automatic int sp_home(input logic [2:0] b);
    case (b)
      BANK_USR: return 5;
      BANK_IRQ: return 14;
      BANK_SVC: return 16;
      BANK_ABT: return 18;
      BANK_UND: return 20;
      default:  return 0;
    endcase
  endfunction

  function automatic void swap_banks(input logic [2:0] from_b, input logic [2:0] to_b);
    int i;
    if (from_b == to_b) return;
    bank_swaps++;
    if (from_b == BANK_FIQ) begin
      for (i = 8; i < 15; i++) shadow[i - 1] = gpr[i];
    end else if (from_b != BANK_DUM) begin
      // user r8..r12 only need saving when FIQ takes them over
      if (to_b == BANK_FIQ)
        for (i = 8; i < 13; i++) shadow[i - 8] = gpr[i];
      shadow[sp_home(from_b)]     = gpr[13];
      shadow[sp_home(from_b) + 1] = gpr[14];
    end
    if (to_b == BANK_FIQ) begin
      for (i = 8; i < 15; i++) gpr[i] = shadow[i - 1];
    end else if (to_b == BANK_DUM) begin
      for (i = 8; i < 15; i++) gpr[i] = '0;
    end else begin
      if (from_b == BANK_FIQ)
        for (i = 8; i < 13; i++) gpr[i] = shadow[i - 8];
      gpr[13] = shadow[sp_home(to_b)];
      gpr[14] = shadow[sp_home(to_b) + 1];
    end
  endfunction

  function automatic rf_result_t regfile_step(input rf_access_t a);
    rf_result_t r;
    r = '0;
    case (a.op)
      OP_READ: begin
        r.rval = gpr[a.idx];
        n_reads++;
      end
      OP_WRITE: begin
        gpr[a.idx] = a.wval;
        n_writes++;
      end
      OP_MODE: begin
        swap_banks(mode_bank(cur_mode), mode_bank(a.nmode));
        cur_mode = a.nmode;
        n_modes++;
      end
      default: ;
    endcase
    r.bank = mode_bank(cur_mode);
    r.mode = cur_mode;
    return r;
  endfunction

  function automatic void note_mismatch(input string what, input logic [31:0] exp_v,
                                        input logic [31:0] got_v);
    mismatches++;
    if (mismatches <= 10)
      $display("ERROR %0t: %s expected 0x%08h got 0x%08h", $realtime, what, exp_v, got_v);
  endfunction

  function automatic void queue_access(input logic [1:0] op, input logic [3:0] idx,
                                       input logic [31:0] wval, input logic [4:0] nmode);
    access_q.push_back(rf_access_t'{op, idx, wval, nmode});
  endfunction

  // driver: new transfer offered at the falling edge once the last one went through
  always @(negedge clk_i) begin
    out_stall_i <= !quiet && ($urandom_range(99) < 6);
    if (rst_ni && (!in_valid_i || in_xfer)) begin
      if (access_q.size() != 0 && (quiet || $urandom_range(99) >= 6)) begin
        next_access = access_q.pop_front();
        in_valid_i    <= 1'b1;
        op_i          <= next_access.op;
        reg_index_i   <= next_access.idx;
        write_value_i <= next_access.wval;
        new_mode_i    <= next_access.nmode;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // monitor: predict on input transfer, check on output transfer
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_xfer <= 1'b0;
    end else begin
      in_xfer <= in_valid_i && !in_stall_o;
      if (in_valid_i && !in_stall_o) begin
        result_q.push_back(regfile_step(
          rf_access_t'{op_i, reg_index_i, write_value_i, new_mode_i}));
        n_taken++;
      end
      if (out_valid_o && !out_stall_i) begin
        if (result_q.size() == 0) begin
          note_mismatch("result with nothing pending, read_value", '0, read_value_o);
        end else begin
          want = result_q.pop_front();
          n_checked++;
          if (read_value_o !== want.rval)
            note_mismatch("read_value", want.rval, read_value_o);
          if (active_bank_o !== want.bank)
            note_mismatch("active_bank", 32'(want.bank), 32'(active_bank_o));
          if (active_mode_o !== want.mode)
            note_mismatch("active_mode", 32'(want.mode), 32'(active_mode_o));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        stuck <= 0;
      end else begin
        stuck <= stuck + 1;
        if (stuck == STUCK_LIMIT) begin
          $display("ERROR: no transfer for %0d cycles", STUCK_LIMIT);
          $display("banked_register_file_mode_switch_unit_tb NOT OK");
          $finish;
        end
      end
    end
  end

  logic [4:0] legal_modes[11] = '{5'd16, 5'd17, 5'd18, 5'd19, 5'd23, 5'd27, 5'd31,
                                  5'd0, 5'd1, 5'd2, 5'd3};

  initial begin
    int n;
    int pick;
    logic [1:0]  op;
    logic [3:0]  idx;
    logic [31:0] wval;
    logic [4:0]  nmode;

    for (n = 0; n < 16; n++) gpr[n] = '0;
    for (n = 0; n < 22; n++) shadow[n] = '0;
    cur_mode = MODE_RESET;

    // directed
    queue_access(OP_WRITE, 4'd15, 32'hFFFF_FFFF, 5'd0);
    queue_access(OP_READ,  4'd15, '0, 5'd31);
    queue_access(OP_WRITE, 4'd13, 32'h1357_9BDF, 5'd0);
    queue_access(OP_WRITE, 4'd8,  32'hA5A5_0008, 5'd0);
    queue_access(OP_MODE,  4'd0,  '0, 5'd17);            // user -> FIQ
    queue_access(OP_READ,  4'd8,  '0, 5'd0);
    queue_access(OP_WRITE, 4'd8,  32'h0F0F_F0F0, 5'd0);
    queue_access(OP_MODE,  4'd0,  '0, 5'd1);             // same bank
    queue_access(OP_MODE,  4'd0,  '0, 5'd4);             // into dummy
    queue_access(OP_READ,  4'd13, '0, 5'd0);
    queue_access(OP_WRITE, 4'd14, 32'hDEAD_BEEF, 5'd0);
    queue_access(OP_MODE,  4'd0,  '0, 5'd5);             // dummy to dummy
    queue_access(OP_MODE,  4'd0,  '0, 5'd18);            // out of dummy to IRQ
    queue_access(OP_READ,  4'd8,  '0, 5'd0);
    queue_access(OP_READ,  4'd13, '0, 5'd0);
    queue_access(OP_NONE,  4'hF,  32'hFFFF_FFFF, 5'd31);
    queue_access(OP_MODE,  4'd0,  '0, 5'd31);            // system acts as user
    queue_access(OP_READ,  4'd13, '0, 5'd0);
    queue_access(OP_MODE,  4'd0,  '0, 5'd0);
    queue_access(OP_WRITE, 4'd0,  '0, 5'd0);
    queue_access(OP_READ,  4'd0,  '0, 5'd0);
    queue_access(OP_MODE,  4'd0,  '0, 5'd23);
    queue_access(OP_MODE,  4'd0,  '0, 5'd27);
    queue_access(OP_MODE,  4'd0,  '0, 5'd19);
    queue_access(OP_MODE,  4'd0,  '0, 5'd17);            // back into FIQ
    queue_access(OP_READ,  4'd8,  '0, 5'd0);

    // random, mostly legal modes with banked registers favored
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      pick = $urandom_range(99);
      op = (pick < 40) ? OP_READ : (pick < 75) ? OP_WRITE : (pick < 95) ? OP_MODE : OP_NONE;
      idx = ($urandom_range(1) == 0) ? 4'($urandom_range(14, 8)) : 4'($urandom_range(15));
      case ($urandom_range(15))
        0:       wval = '0;
        1:       wval = 32'hFFFF_FFFF;
        default: wval = $urandom();
      endcase
      nmode = ($urandom_range(3) != 0) ? legal_modes[$urandom_range(10)]
                                       : 5'($urandom_range(31));
      queue_access(op, idx, wval, nmode);
    end

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (access_q.size() != 0 || in_valid_i) @(posedge clk_i);
    while (result_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Covered %0d transfers: %0d reads, %0d writes, %0d mode changes (%0d bank swaps).",
             n_taken, n_reads, n_writes, n_modes, bank_swaps);
    $display("Checked %0d results, %0d mismatches.", n_checked, mismatches);
    if (mismatches == 0) begin
      $display("banked_register_file_mode_switch_unit_tb OK");
    end else begin
      $display("banked_register_file_mode_switch_unit_tb NOT OK");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/brf_ms_pkg.sv
sv/banked_register_file_mode_switch_unit.sv
sim/banked_register_file_mode_switch_unit_tb.sv
